// File: sv/tcpq_pkg.sv
// Shared types and constants for the two-class priority queue.
// No dependencies; imported by tcpq_cell and two_class_priority_queue.
package tcpq_pkg;

	localparam int DATA_W = 32;
	localparam int OCC_W  = 5;

	localparam logic signed [DATA_W-1:0] THRESHOLD_RESET = 32'sd59;

	typedef enum logic [1:0] {
		MODE_PUSH = 2'd0,
		MODE_PRIO = 2'd1,
		MODE_POP  = 2'd2,
		MODE_NOP  = 2'd3
	} mode_t;

	// Per-cycle command broadcast to every cell
	typedef struct packed {
		logic ins;   // insert value this cycle (queue not full)
		logic pop;   // shift toward head this cycle (queue not empty)
		logic prio;  // place behind the leading run of high entries
	} cell_ctl_t;

endpackage

// File: sv/tcpq_cell.sv
// One storage cell of the priority queue chain.
// Holds a value and an occupied bit; depends on tcpq_pkg.
module tcpq_cell
	import tcpq_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  cell_ctl_t                ctl,
	input  logic signed [DATA_W-1:0] threshold,
	input  logic signed [DATA_W-1:0] value,
	input  logic signed [DATA_W-1:0] left_data,
	input  logic                     left_occ,
	input  logic signed [DATA_W-1:0] right_data,
	input  logic                     right_occ,
	input  logic                     chain_in,
	output logic                     chain_out,
	output logic signed [DATA_W-1:0] data,
	output logic                     occ
);

	logic signed [DATA_W-1:0] data_q;
	logic                     occ_q;
	logic                     high;
	logic                     keep;

	assign high = data_q > threshold;
	// cell stays ahead of the insert point
	assign keep = occ_q && (!ctl.prio || high);
	assign chain_out = chain_in && keep;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
		end else if (ctl.ins) begin
			if (!chain_in) begin
				occ_q <= left_occ;
			end else if (!keep) begin
				occ_q <= 1'b1;
			end
		end else if (ctl.pop) begin
			occ_q <= right_occ;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (!chain_in) begin
				data_q <= left_data;
			end else if (!keep) begin
				data_q <= value;
			end
		end else if (ctl.pop) begin
			data_q <= right_data;
		end
	end

	assign data = data_q;
	assign occ  = occ_q;

endmodule

// File: sv/two_class_priority_queue.sv
// Top level of the two-class priority queue: a chain of tcpq_cell instances,
// count, threshold register and output register. Depends on tcpq_pkg and tcpq_cell.
//
// One operation is accepted per clock cycle while in_ready is high; its result is
// loaded into the output register, and a new operation is taken whenever that
// register is empty or being drained. The cycle time is set by the insert-point
// chain, which ripples one bit through all QUEUE_DEPTH cells after each cell's
// 32-bit threshold compare. Entries shift one cell toward the tail on insert and
// toward the head on pop. The threshold write port is always ready.
module two_class_priority_queue
	import tcpq_pkg::*;
#(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [1:0]               mode,
	input  logic signed [DATA_W-1:0] value,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [DATA_W-1:0] removed_value,
	output logic                     removed_valid,
	output logic                     empty_alert,
	output logic                     full_drop,
	output logic [OCC_W-1:0]         occupancy,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic signed [DATA_W-1:0] cfg_data
);

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic signed [DATA_W-1:0] threshold_q;
	logic [CNT_W-1:0]         cnt_q;
	logic [CNT_W-1:0]         cnt_next;
	logic                     out_valid_q;
	logic signed [DATA_W-1:0] removed_value_q;
	logic                     removed_valid_q;
	logic                     empty_alert_q;
	logic                     full_drop_q;
	logic [OCC_W-1:0]         occupancy_q;

	logic                     accept;
	logic                     is_ins;
	logic                     is_pop;
	logic                     full;
	logic                     empty;
	cell_ctl_t                ctl;

	logic signed [DATA_W-1:0] cell_data [QUEUE_DEPTH];
	logic                     cell_occ  [QUEUE_DEPTH];
	logic                     chain     [QUEUE_DEPTH+1];

	assign in_ready  = !out_valid_q || out_ready;
	assign accept    = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	assign is_ins = (mode == MODE_PUSH) || (mode == MODE_PRIO);
	assign is_pop = (mode == MODE_POP);
	assign full   = (cnt_q == CNT_W'(QUEUE_DEPTH));
	assign empty  = (cnt_q == '0);

	always_comb begin
		ctl.ins  = accept && is_ins && !full;
		ctl.pop  = accept && is_pop && !empty;
		ctl.prio = (mode == MODE_PRIO) && (value > threshold_q);
	end

	always_comb begin
		cnt_next = cnt_q;
		if (ctl.ins) begin
			cnt_next = cnt_q + 1'b1;
		end else if (ctl.pop) begin
			cnt_next = cnt_q - 1'b1;
		end
	end

	assign chain[0] = 1'b1;

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		logic signed [DATA_W-1:0] ldata;
		logic                     locc;
		logic signed [DATA_W-1:0] rdata;
		logic                     rocc;

		if (i == 0) begin : g_head
			assign ldata = '0;
			assign locc  = 1'b0;
		end else begin : g_mid_l
			assign ldata = cell_data[i-1];
			assign locc  = cell_occ[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_tail
			assign rdata = '0;
			assign rocc  = 1'b0;
		end else begin : g_mid_r
			assign rdata = cell_data[i+1];
			assign rocc  = cell_occ[i+1];
		end

		tcpq_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.threshold  (threshold_q),
			.value      (value),
			.left_data  (ldata),
			.left_occ   (locc),
			.right_data (rdata),
			.right_occ  (rocc),
			.chain_in   (chain[i]),
			.chain_out  (chain[i+1]),
			.data       (cell_data[i]),
			.occ        (cell_occ[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RESET;
		end else if (cfg_valid && cfg_ready) begin
			threshold_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			cnt_q <= cnt_next;
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Load the result of the transfer accepted this cycle
	always_ff @(posedge clk) begin
		if (accept) begin
			removed_value_q <= ctl.pop ? cell_data[0] : '0;
			removed_valid_q <= ctl.pop;
			empty_alert_q   <= is_pop && empty;
			full_drop_q     <= is_ins && full;
			occupancy_q     <= OCC_W'(cnt_next);
		end
	end

	assign out_valid     = out_valid_q;
	assign removed_value = removed_value_q;
	assign removed_valid = removed_valid_q;
	assign empty_alert   = empty_alert_q;
	assign full_drop     = full_drop_q;
	assign occupancy     = occupancy_q;

endmodule
